// File: rtl/core/rea_pkg.sv
// Shared types, constants and helpers for the reprojection error accumulator.
`default_nettype none
package rea_pkg;

    localparam int MAX_CAMERAS_DEF    = 256;
    localparam int MAX_INTRINSICS_DEF = 16;
    localparam int E_ELEMS            = 12;
    localparam int K_ELEMS            = 9;
    localparam int DIV_STEPS          = 64;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

    localparam logic [47:0] ERR_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_INTR = 2'd0,
        REQ_EXTR = 2'd1,
        REQ_MAP  = 2'd2,
        REQ_OBS  = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         table_index;
        logic [3:0]         element_index;
        logic signed [31:0] load_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] obs_u;
        logic signed [31:0] obs_v;
        logic               last_obs;
    } req_t;

    typedef struct packed {
        logic [47:0] obs_error;
        logic [63:0] total_error;
        logic [31:0] obs_total;
        logic [47:0] average_error;
        logic        bad_depth;
        logic        final_flag;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (x < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/rea_div.sv
// Shared restoring divider: 64-bit dividend, 32-bit divisor, one quotient bit a cycle.
`default_nettype none
module rea_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rea_pkg::div_req_t dreq,
    output rea_pkg::div_rsp_t      drsp
);
    import rea_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [63:0]          num_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          den_reg;

    logic [32:0] shifted;
    logic        take;
    logic [32:0] diff;

    assign shifted = {rem_reg, num_reg[63]};
    assign take    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (dreq.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (dreq.start)
        begin
            num_reg <= dreq.num;
            den_reg <= dreq.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], take};
            rem_reg <= take ? diff[31:0] : shifted[31:0];
        end
    end

    assign drsp.done = done_reg;
    assign drsp.quo  = num_reg;

endmodule
`default_nettype wire

// File: rtl/core/rea_tables.sv
// Intrinsic, extrinsic and camera map memories with registered read ports.
`default_nettype none
module rea_tables #(
    parameter int MAX_CAMERAS    = rea_pkg::MAX_CAMERAS_DEF,
    parameter int MAX_INTRINSICS = rea_pkg::MAX_INTRINSICS_DEF,
    localparam int CAM_W = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1,
    localparam int KI_W  = (MAX_INTRINSICS > 1) ? $clog2(MAX_INTRINSICS) : 1,
    localparam int EA_W  = $clog2(MAX_CAMERAS * rea_pkg::E_ELEMS),
    localparam int KA_W  = $clog2(MAX_INTRINSICS * rea_pkg::K_ELEMS)
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire rea_pkg::req_t      wr,
    input  wire logic [CAM_W-1:0]   map_addr,
    input  wire logic [EA_W-1:0]    e_addr,
    input  wire logic [KA_W-1:0]    k_addr,
    output logic [KI_W-1:0]         map_rd,
    output logic signed [31:0]      e_rd,
    output logic signed [31:0]      k_rd
);
    import rea_pkg::*;

    logic signed [31:0] k_mem [MAX_INTRINSICS * K_ELEMS];
    logic signed [31:0] e_mem [MAX_CAMERAS * E_ELEMS];
    logic [KI_W-1:0]    map_mem [MAX_CAMERAS];

    logic            k_we, e_we, map_we;
    logic [KA_W-1:0] k_wa;
    logic [EA_W-1:0] e_wa;

    assign k_we = wr_en && (wr.req_type == REQ_INTR)
        && (32'(wr.table_index) < MAX_INTRINSICS) && (wr.element_index < 4'(K_ELEMS));
    assign e_we = wr_en && (wr.req_type == REQ_EXTR)
        && (32'(wr.table_index) < MAX_CAMERAS) && (wr.element_index < 4'(E_ELEMS));
    assign map_we = wr_en && (wr.req_type == REQ_MAP)
        && (32'(wr.table_index) < MAX_CAMERAS)
        && !wr.load_value[31] && (wr.load_value < MAX_INTRINSICS);

    assign k_wa = KA_W'(wr.table_index) * KA_W'(K_ELEMS) + KA_W'(wr.element_index);
    assign e_wa = EA_W'(wr.table_index) * EA_W'(E_ELEMS) + EA_W'(wr.element_index);

    always_ff @(posedge clk)
    begin
        if (k_we)
            k_mem[k_wa] <= wr.load_value;
        k_rd <= k_mem[k_addr];
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
            e_mem[e_wa] <= wr.load_value;
        e_rd <= e_mem[e_addr];
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[CAM_W'(wr.table_index)] <= KI_W'(wr.load_value);
        map_rd <= map_mem[map_addr];
    end

endmodule
`default_nettype wire

// File: rtl/core/reprojection_error_accumulator.sv
// Top level: observation sequencer with shared multiplier, divider and table memories.
//
// Requests arrive on req (req_valid/req_ready); results leave on res (res_valid/res_ready).
// Table writes (intrinsic, extrinsic, map) produce no result.
// An observation produces one result. It walks one shared 34x34 multiplier through
// 21 multiply-accumulate steps (memory read, multiply, add; a translation term is a
// read and an add), then runs two divisions for u and v on the shared divider, two
// squaring steps and the saturating accumulate. Non-positive depth skips the divisions
// and squares. An observation marked last runs a third division for the average.
// req_ready is high only while the sequencer is idle. A finished result sits in an
// output register; a new request is taken while it waits, and the next result
// holds in the sequencer until that register is free, so a stalled receiver
// backs up the request side after one result.
// Reset clears the running sum, the count and all handshake state; the tables
// hold unknown data until written.
`default_nettype none
module reprojection_error_accumulator #(
    parameter int MAX_CAMERAS    = rea_pkg::MAX_CAMERAS_DEF,
    parameter int MAX_INTRINSICS = rea_pkg::MAX_INTRINSICS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire rea_pkg::req_t req,
    output logic               res_valid,
    input  wire logic          res_ready,
    output rea_pkg::res_t      res
);
    import rea_pkg::*;

    localparam int CAM_W = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
    localparam int KI_W  = (MAX_INTRINSICS > 1) ? $clog2(MAX_INTRINSICS) : 1;
    localparam int EA_W  = $clog2(MAX_CAMERAS * E_ELEMS);
    localparam int KA_W  = $clog2(MAX_INTRINSICS * K_ELEMS);

    typedef enum logic [4:0] {
        S_IDLE, S_MAP, S_KI, S_ERD, S_EMUL, S_EACC, S_KRD, S_KMUL, S_KACC,
        S_DEPTH, S_DIVU, S_DIVV, S_SQU, S_SQV, S_ERR, S_SUM, S_AVG, S_PUSH
    } state_t;

    state_t             state_reg, state_next;
    req_t               obs_reg, obs_next;
    logic               cam_ok_reg, cam_ok_next;
    logic [CAM_W-1:0]   cam_reg, cam_next;
    logic [KI_W-1:0]    ki_reg, ki_next;
    logic [1:0]         row_reg, row_next;
    logic [1:0]         col_reg, col_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] c_reg [3];
    logic signed [31:0] c_next [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] p_next [3];
    logic [63:0]        mul_reg, mul_next;
    logic               sgn_reg, sgn_next;
    logic [31:0]        qu_reg, qu_next, qv_reg, qv_next;
    logic               ru_reg, ru_next, rv_reg, rv_next;
    logic               huge_reg, huge_next;
    logic [63:0]        xu_reg, xu_next;
    logic [47:0]        err_reg, err_next;
    logic               bad_reg, bad_next;
    logic [63:0]        sum_reg, sum_next;
    logic [31:0]        cnt_reg, cnt_next;
    logic [63:0]        tot_reg, tot_next;
    logic [31:0]        tcnt_reg, tcnt_next;
    logic [47:0]        avg_reg, avg_next;
    res_t               res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               wr_en;
    logic [EA_W-1:0]    e_addr;
    logic [KA_W-1:0]    k_addr;
    logic [KI_W-1:0]    map_rd;
    logic signed [31:0] e_rd, k_rd, e_op, k_op, pt_sel, c_sel;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    div_req_t           dreq;
    div_rsp_t           drsp;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [32:0] e;
        e = {x[31], x};
        if (x[31])
            e = -e;
        return e[31:0];
    endfunction

    // |o - u| with u the signed quotient
    function automatic logic [63:0] abs_diff(input logic signed [31:0] o,
                                             input logic [63:0] q, input logic neg);
        logic signed [63:0] u;
        logic signed [63:0] d;
        u = neg ? -$signed(q) : $signed(q);
        d = 64'(o) - u;
        return d[63] ? 64'(-d) : 64'(d);
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign wr_en     = req_valid && req_ready && (req.req_type != REQ_OBS);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    rea_tables #(
        .MAX_CAMERAS    (MAX_CAMERAS),
        .MAX_INTRINSICS (MAX_INTRINSICS)
    ) u_tables (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr       (req),
        .map_addr (cam_reg),
        .e_addr   (e_addr),
        .k_addr   (k_addr),
        .map_rd   (map_rd),
        .e_rd     (e_rd),
        .k_rd     (k_rd)
    );

    rea_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .dreq  (dreq),
        .drsp  (drsp)
    );

    assign e_addr = EA_W'(cam_reg) * EA_W'(E_ELEMS) + EA_W'({row_reg, col_reg});
    assign k_addr = KA_W'(ki_reg) * KA_W'(K_ELEMS) + KA_W'({row_reg, 1'b0})
        + KA_W'(row_reg) + KA_W'(col_reg);

    // an out-of-range camera sees an all-zero matrix
    assign e_op = cam_ok_reg ? e_rd : 32'sd0;
    assign k_op = cam_ok_reg ? k_rd : 32'sd0;

    always_comb
    begin
        case (col_reg)
            2'd0:    pt_sel = obs_reg.point_x;
            2'd1:    pt_sel = obs_reg.point_y;
            default: pt_sel = obs_reg.point_z;
        endcase
        case (col_reg)
            2'd0:    c_sel = c_reg[0];
            2'd1:    c_sel = c_reg[1];
            default: c_sel = c_reg[2];
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_EMUL:
            begin
                mul_a = 34'(e_op);
                mul_b = 34'(pt_sel);
            end
            S_KMUL:
            begin
                mul_a = 34'(k_op);
                mul_b = 34'(c_sel);
            end
            S_SQU:
            begin
                mul_a = $signed({2'b00, qu_reg});
                mul_b = $signed({1'b0, 33'(qu_reg) + 33'(ru_reg)});
            end
            S_SQV:
            begin
                mul_a = $signed({2'b00, qv_reg});
                mul_b = $signed({1'b0, 33'(qv_reg) + 33'(rv_reg)});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod     = mul_a * mul_b;
        mul_next = prod[63:0];
    end

    always_comb
    begin
        logic signed [63:0] term;
        logic signed [63:0] total;
        logic [63:0]        m;
        logic [64:0]        sum65;
        logic [49:0]        sh;
        logic [64:0]        add65;

        state_next     = state_reg;
        obs_next       = obs_reg;
        cam_ok_next    = cam_ok_reg;
        cam_next       = cam_reg;
        ki_next        = ki_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        acc_next       = acc_reg;
        c_next         = c_reg;
        p_next         = p_reg;
        sgn_next       = sgn_reg;
        qu_next        = qu_reg;
        qv_next        = qv_reg;
        ru_next        = ru_reg;
        rv_next        = rv_reg;
        huge_next      = huge_reg;
        xu_next        = xu_reg;
        err_next       = err_reg;
        bad_next       = bad_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        tot_next       = tot_reg;
        tcnt_next      = tcnt_reg;
        avg_next       = avg_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        dreq           = '0;
        term           = $signed(mul_reg) >>> 16;
        total          = acc_reg + term;
        m              = '0;
        sum65          = 65'(xu_reg) + 65'(mul_reg);
        sh             = sum65[64:15];
        add65          = 65'(sum_reg) + 65'(err_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req.req_type == REQ_OBS)
                begin
                    obs_next    = req;
                    cam_ok_next = 32'(req.table_index) < MAX_CAMERAS;
                    cam_next    = CAM_W'(req.table_index);
                    row_next    = '0;
                    col_next    = '0;
                    acc_next    = '0;
                    state_next  = S_MAP;
                end
            end
            S_MAP:
                state_next = S_KI;
            S_KI:
            begin
                ki_next    = (32'(map_rd) < MAX_INTRINSICS) ? map_rd : '0;
                state_next = S_ERD;
            end
            S_ERD:
                state_next = S_EMUL;
            S_EMUL:
            begin
                if (col_reg == 2'd3)
                begin
                    // translation column closes the row
                    c_next[row_reg] = sat32(acc_reg + 64'(e_op));
                    acc_next        = '0;
                    col_next        = '0;
                    if (row_reg == 2'd2)
                    begin
                        row_next   = '0;
                        state_next = S_KRD;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = S_ERD;
                    end
                end
                else
                    state_next = S_EACC;
            end
            S_EACC:
            begin
                acc_next   = total;
                col_next   = col_reg + 2'd1;
                state_next = S_ERD;
            end
            S_KRD:
                state_next = S_KMUL;
            S_KMUL:
                state_next = S_KACC;
            S_KACC:
            begin
                if (col_reg == 2'd2)
                begin
                    p_next[row_reg] = sat32(total);
                    acc_next        = '0;
                    col_next        = '0;
                    if (row_reg == 2'd2)
                    begin
                        row_next   = '0;
                        state_next = S_DEPTH;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = S_KRD;
                    end
                end
                else
                begin
                    acc_next   = total;
                    col_next   = col_reg + 2'd1;
                    state_next = S_KRD;
                end
            end
            S_DEPTH:
            begin
                huge_next = 1'b0;
                if (p_reg[2] <= 32'sd0)
                begin
                    bad_next   = 1'b1;
                    err_next   = ERR_MAX;
                    state_next = S_SUM;
                end
                else
                begin
                    bad_next   = 1'b0;
                    sgn_next   = p_reg[0][31];
                    dreq.start = 1'b1;
                    dreq.num   = {16'b0, mag32(p_reg[0]), 16'b0};
                    dreq.den   = p_reg[2];
                    state_next = S_DIVU;
                end
            end
            S_DIVU:
            begin
                if (drsp.done)
                begin
                    m          = abs_diff(obs_reg.obs_u, drsp.quo, sgn_reg);
                    huge_next  = |m[63:33];
                    qu_next    = m[32:1];
                    ru_next    = m[0];
                    sgn_next   = p_reg[1][31];
                    dreq.start = 1'b1;
                    dreq.num   = {16'b0, mag32(p_reg[1]), 16'b0};
                    dreq.den   = p_reg[2];
                    state_next = S_DIVV;
                end
            end
            S_DIVV:
            begin
                if (drsp.done)
                begin
                    m          = abs_diff(obs_reg.obs_v, drsp.quo, sgn_reg);
                    huge_next  = huge_reg || (|m[63:33]);
                    qv_next    = m[32:1];
                    rv_next    = m[0];
                    state_next = S_SQU;
                end
            end
            S_SQU:
                state_next = S_SQV;
            S_SQV:
            begin
                xu_next    = mul_reg;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                if (huge_reg || xu_reg[63] || mul_reg[63] || (|sh[49:48]))
                    err_next = ERR_MAX;
                else
                    err_next = sh[47:0];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                tot_next  = add65[64] ? '1 : add65[63:0];
                tcnt_next = (cnt_reg == '1) ? cnt_reg : cnt_reg + 32'd1;
                if (obs_reg.last_obs)
                begin
                    sum_next   = '0;
                    cnt_next   = '0;
                    dreq.start = 1'b1;
                    dreq.num   = tot_next;
                    dreq.den   = tcnt_next;
                    state_next = S_AVG;
                end
                else
                begin
                    sum_next   = tot_next;
                    cnt_next   = tcnt_next;
                    avg_next   = '0;
                    state_next = S_PUSH;
                end
            end
            S_AVG:
            begin
                if (drsp.done)
                begin
                    avg_next   = (|drsp.quo[63:48]) ? ERR_MAX : drsp.quo[47:0];
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // hold until the output register is free
                if (!res_valid_reg || res_ready)
                begin
                    res_next.obs_error     = err_reg;
                    res_next.total_error   = tot_reg;
                    res_next.obs_total     = tcnt_reg;
                    res_next.average_error = avg_reg;
                    res_next.bad_depth     = bad_reg;
                    res_next.final_flag    = obs_reg.last_obs;
                    res_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        obs_reg    <= obs_next;
        cam_ok_reg <= cam_ok_next;
        cam_reg    <= cam_next;
        ki_reg     <= ki_next;
        row_reg    <= row_next;
        col_reg    <= col_next;
        acc_reg    <= acc_next;
        c_reg      <= c_next;
        p_reg      <= p_next;
        mul_reg    <= mul_next;
        sgn_reg    <= sgn_next;
        qu_reg     <= qu_next;
        qv_reg     <= qv_next;
        ru_reg     <= ru_next;
        rv_reg     <= rv_next;
        huge_reg   <= huge_next;
        xu_reg     <= xu_next;
        err_reg    <= err_next;
        bad_reg    <= bad_next;
        tot_reg    <= tot_next;
        tcnt_reg   <= tcnt_next;
        avg_reg    <= avg_next;
        res_reg    <= res_next;
    end

endmodule
`default_nettype wire

// File: rtl/core/rea_checker.sv
// Port-level checks for the reprojection error accumulator, bound to the top level.
`default_nettype none
module rea_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire rea_pkg::req_t req,
    input wire logic          res_valid,
    input wire logic          res_ready,
    input wire rea_pkg::res_t res
);
    import rea_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_obs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.req_type == REQ_OBS |=> !req_ready)
        else $error("ready right after an observation transfer");

    a_bad_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.bad_depth |-> res.obs_error == ERR_MAX)
        else $error("bad depth without saturated error");

    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.final_flag |-> res.average_error == 48'd0)
        else $error("average reported on a non-final result");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.obs_total != 32'd0 && res.total_error >= 64'(res.obs_error))
        else $error("count or sum inconsistent");

endmodule

bind reprojection_error_accumulator rea_checker u_rea_checker (.*);
`default_nettype wire
